// ----- sv/dq_pkg.sv -----
// Shared types, sizes and ring-index helpers for the bounded deque with search.
// No dependencies; every other file in this folder imports it.
package dq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned OCC_W       = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned CMDQ_IDX_W  = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  // Request codes as they arrive on the port.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SEARCH,
    OP_NOP
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

  // (a + b) mod DEPTH for ring positions.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // (a - 1) mod DEPTH.
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = a - IDX_W'(1);
    end
    return r;
  endfunction

  // (a - b) mod DEPTH: distance of position a from position b.
  function automatic logic [IDX_W-1:0] ring_sub(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (IDX_W+1)'(DEPTH) - {1'b0, b};
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/dq_front.sv -----
// Front end: accepts requests and decodes the request code into a command.
// Depends on dq_pkg.
module dq_front (
  input  logic                       start,
  output logic                       busy,
  input  logic [dq_pkg::REQ_W-1:0]   req_type_i,
  input  logic [dq_pkg::VAL_W-1:0]   item_value_i,
  input  dq_pkg::cmdq_stat_t         cmdq_stat_i,
  output logic                       cmdq_push_o,
  output dq_pkg::cmd_t               cmdq_data_o
);
  import dq_pkg::*;

  op_e op;

  always_comb begin
    case (req_type_i)
      REQ_PUSH_FRONT: op = OP_PUSH_FRONT;
      REQ_PUSH_BACK:  op = OP_PUSH_BACK;
      REQ_POP_FRONT:  op = OP_POP_FRONT;
      REQ_POP_BACK:   op = OP_POP_BACK;
      REQ_SEARCH:     op = OP_SEARCH;
      default:        op = OP_NOP;
    endcase
  end

  assign busy              = cmdq_stat_i.full;
  assign cmdq_push_o       = start && !cmdq_stat_i.full;
  assign cmdq_data_o.op    = op;
  assign cmdq_data_o.value = item_value_i;

endmodule

// ----- sv/dq_cmdq.sv -----
// Small command queue between the front end and the execution back end.
// Depends on dq_pkg.
module dq_cmdq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dq_pkg::cmd_t       push_data_i,
  input  logic               pop_i,
  output dq_pkg::cmd_t       pop_data_o,
  output dq_pkg::cmdq_stat_t stat_o
);
  import dq_pkg::*;

  cmd_t                  mem_q [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/dq_back.sv -----
// Back end: holds the ring of entries, front pointer and occupancy, executes
// one command per cycle and registers the result. Depends on dq_pkg.
module dq_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  dq_pkg::cmd_t                cmd_i,
  output logic                        cmd_pop_o,
  output logic                        done_o,
  output logic [dq_pkg::STATUS_W-1:0] status_o,
  output logic                        found_o,
  output logic [dq_pkg::COUNT_W-1:0]  count_o
);
  import dq_pkg::*;

  logic [VAL_W-1:0] entry_q [DEPTH];
  logic [IDX_W-1:0] front_q, front_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [DEPTH-1:0] hit;
  logic             q_full, q_empty;
  status_e          status;
  logic             found;

  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic                found_q;
  logic [COUNT_W-1:0]  count_q;

  assign q_full    = (occ_q == OCC_W'(DEPTH));
  assign q_empty   = (occ_q == '0);
  assign cmd_pop_o = cmd_valid_i;

  // Compare every live entry against the search value in parallel.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (OCC_W'(ring_sub(IDX_W'(i), front_q)) < occ_q) &&
               (entry_q[i] == cmd_i.value);
    end
  end

  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    wr_en   = 1'b0;
    wr_idx  = ring_add(front_q, IDX_W'(occ_q));
    status  = ST_OK;
    found   = 1'b0;
    case (cmd_i.op)
      OP_PUSH_FRONT: begin
        if (q_full) begin
          status = ST_FULL;
        end else begin
          front_d = ring_dec(front_q);
          wr_idx  = front_d;
          wr_en   = 1'b1;
          occ_d   = occ_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (q_full) begin
          status = ST_FULL;
        end else begin
          wr_en = 1'b1;
          occ_d = occ_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          front_d = ring_add(front_q, IDX_W'(1));
          occ_d   = occ_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          occ_d = occ_q - 1'b1;
        end
      end
      OP_SEARCH: begin
        found = |hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_valid_i;
      if (cmd_valid_i) begin
        front_q <= front_d;
        occ_q   <= occ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      status_q <= status;
      found_q  <= found;
      count_q  <= COUNT_W'(occ_d);
      if (wr_en) begin
        entry_q[wr_idx] <= cmd_i.value;
      end
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign found_o  = found_q;
  assign count_o  = count_q;

endmodule

// ----- sv/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search: front end, command queue, back end.
// Depends on dq_pkg, dq_front, dq_cmdq and dq_back.
//
//   channel   handshake          payload
//   request   start / busy       req_type_i, item_value_i
//   result    done_o (strobe)    status_o, found_o, count_o
//
// A request is decoded and written into the two-entry command queue; the back
// end reads it from there, executes one command per cycle and registers its
// result, which strobes on done_o.
// Throughput is one item per cycle while busy is low, set by the parallel search.
// Reset clears front pointer, occupancy and queue; entry contents stay unset.
// The receiver cannot stall; busy rises only when the command queue is full.
module bounded_deque_with_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [dq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [dq_pkg::VAL_W-1:0]    item_value_i,
  output logic                        done_o,
  output logic [dq_pkg::STATUS_W-1:0] status_o,
  output logic                        found_o,
  output logic [dq_pkg::COUNT_W-1:0]  count_o
);
  import dq_pkg::*;

  cmdq_stat_t cmdq_stat;
  logic       cmdq_push;
  cmd_t       cmdq_wdata;
  logic       cmdq_pop;
  cmd_t       cmdq_rdata;

  dq_front u_front (
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .cmdq_stat_i  (cmdq_stat),
    .cmdq_push_o  (cmdq_push),
    .cmdq_data_o  (cmdq_wdata)
  );

  dq_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmdq_push),
    .push_data_i (cmdq_wdata),
    .pop_i       (cmdq_pop),
    .pop_data_o  (cmdq_rdata),
    .stat_o      (cmdq_stat)
  );

  dq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmdq_stat.empty),
    .cmd_i       (cmdq_rdata),
    .cmd_pop_o   (cmdq_pop),
    .done_o      (done_o),
    .status_o    (status_o),
    .found_o     (found_o),
    .count_o     (count_o)
  );

endmodule
